/* hdl/rgb_to_hsv_converter_macros.svh */
// Assertion macros shared by the RGB to HSV converter.
`ifndef RGB_TO_HSV_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define HSV_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hsv converter check failed");

// Next-cycle implication, disabled during reset
`define HSV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hsv converter check failed");

// Next-cycle implication that also holds across reset
`define HSV_ASSERT_RESET(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("hsv converter reset check failed");

`endif

/* hdl/hsv_pkg.sv */
// Types and constants shared by the RGB to HSV converter.
`timescale 1ns / 1ps
package hsv_pkg;

   // field widths
   localparam int CHAN_W   = 8;
   localparam int HUE_W    = 15;
   localparam int CHAN_MAX = 255;

   // hue fixed point: units of 1/2^HUE_FRAC_BITS degree
   localparam int HUE_FRAC_BITS = 6;
   localparam int HUE_SCALE     = 1 << HUE_FRAC_BITS;
   localparam int HUE_SPAN      = 60 * HUE_SCALE;
   localparam int HUE_GREEN     = 120 * HUE_SCALE;
   localparam int HUE_BLUE      = 240 * HUE_SCALE;
   localparam int HUE_FULL      = 360 * HUE_SCALE;
   localparam int HUE_CALC_W    = $clog2(HUE_FULL + 1);

   // divider sizing: both lanes share one width set
   localparam int HUE_Q_W   = $clog2(HUE_SPAN + 1);
   localparam int DIV_Q_W   = (HUE_Q_W > CHAN_W) ? HUE_Q_W : CHAN_W;
   localparam int HUE_N_W   = $clog2(HUE_SPAN * CHAN_MAX + 1);
   localparam int SAT_N_W   = $clog2(CHAN_MAX * CHAN_MAX + 1);
   localparam int DIV_N_W   = (HUE_N_W > SAT_N_W) ? HUE_N_W : SAT_N_W;
   localparam int CMP_W     = (DIV_N_W > CHAN_W + DIV_Q_W) ? DIV_N_W : CHAN_W + DIV_Q_W;
   localparam int DIV_LANES = 2;

   // lane numbers inside the divider
   localparam int LANE_HUE = 0;
   localparam int LANE_SAT = 1;

   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } sector_type;

   // per-item data that rides alongside the division
   typedef struct packed {
      logic [CHAN_W-1:0] value;
      logic              grey;
      logic              neg;
      sector_type        sector;
   } side_type;

   typedef logic [DIV_LANES-1:0][CMP_W-1:0]   div_word_type;
   typedef logic [DIV_LANES-1:0][CHAN_W-1:0]  div_den_type;
   typedef logic [DIV_LANES-1:0][DIV_Q_W-1:0] div_quo_type;

endpackage

/* hdl/hsv_if.sv */
// Channel interfaces for pixels in and HSV results out.
`timescale 1ns / 1ps

interface hsv_pixel_if;
   import hsv_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red_in;
   logic [CHAN_W-1:0] green_in;
   logic [CHAN_W-1:0] blue_in;

   modport source (output valid, output red_in, output green_in, output blue_in,
                   input ready);
   modport sink   (input valid, input red_in, input green_in, input blue_in,
                   output ready);
endinterface

interface hsv_result_if;
   import hsv_pkg::*;
   logic              valid;
   logic              ready;
   logic [HUE_W-1:0]  hue_out;
   logic [CHAN_W-1:0] saturation_out;
   logic [CHAN_W-1:0] value_out;

   modport source (output valid, output hue_out, output saturation_out,
                   output value_out, input ready);
   modport sink   (input valid, input hue_out, input saturation_out,
                   input value_out, output ready);
endinterface

/* hdl/rgb_to_hsv_converter.sv */
// Top level of the RGB to HSV converter.
//
//   channel    dir  handshake     payload
//   req_chan   in   valid/ready   red_in, green_in, blue_in (8 bits each)
//   rsp_chan   out  valid/ready   hue_out (15), saturation_out (8), value_out (8)
//
// One pixel per clock sustained while results are taken. The pipeline has two
// front stages, one divider stage per quotient bit of the widest lane (hue), and
// the output register.
// Synchronous active-high reset clears all stage valid bits.
// When a result waits at the output, the whole pipeline holds in place and
// req_chan.ready drops; it accepts again the cycle the result is taken.
`timescale 1ns / 1ps
`include "rgb_to_hsv_converter_macros.svh"
module rgb_to_hsv_converter (
   input  logic         clock,
   input  logic         reset,
   hsv_pixel_if.sink    req_chan,
   hsv_result_if.source rsp_chan
);
   import hsv_pkg::*;

   logic         en;
   logic         front_valid, div_valid;
   div_word_type front_num;
   div_den_type  front_den;
   side_type     front_side, div_side;
   div_quo_type  div_quo;

   // pipeline advances unless a result is stuck at the output
   assign en             = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = en;

   hsv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_chan.valid),
      .red       (req_chan.red_in),
      .green     (req_chan.green_in),
      .blue      (req_chan.blue_in),
      .out_valid (front_valid),
      .out_num   (front_num),
      .out_den   (front_den),
      .out_side  (front_side)
   );

   hsv_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_num    (front_num),
      .in_den    (front_den),
      .in_side   (front_side),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

   hsv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid),
      .in_quo    (div_quo),
      .in_side   (div_side),
      .out_valid (rsp_chan.valid),
      .out_hue   (rsp_chan.hue_out),
      .out_sat   (rsp_chan.saturation_out),
      .out_value (rsp_chan.value_out)
   );

   // a stalled output freezes the divider stages too
   `HSV_ASSERT_NEXT(a_stall_freeze, clock, reset, rsp_chan.valid && !rsp_chan.ready, $stable(div_valid) && $stable(div_quo))
   // zero saturation means a grey pixel, whose hue is zero
   `HSV_ASSERT_NOW(a_grey_hue, clock, reset, rsp_chan.valid && rsp_chan.saturation_out == '0, rsp_chan.hue_out == '0)
   // any saturation needs a nonzero maximum
   `HSV_ASSERT_NOW(a_sat_value, clock, reset, rsp_chan.valid && rsp_chan.saturation_out != '0, rsp_chan.value_out != '0)
   // nothing leaves right after reset
   `HSV_ASSERT_RESET(a_reset_empty, clock, reset, !rsp_chan.valid)

endmodule

/* hdl/hsv_front.sv */
// Front stages: max/min, sector and channel difference, then divider operands.
`timescale 1ns / 1ps
module hsv_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [hsv_pkg::CHAN_W-1:0]  red,
   input  logic [hsv_pkg::CHAN_W-1:0]  green,
   input  logic [hsv_pkg::CHAN_W-1:0]  blue,
   output logic                        out_valid,
   output hsv_pkg::div_word_type       out_num,
   output hsv_pkg::div_den_type        out_den,
   output hsv_pkg::side_type           out_side
);
   import hsv_pkg::*;

   logic [CHAN_W-1:0] mx, mn;
   logic [CHAN_W:0]   diff_s;
   sector_type        sector;

   logic              s1_valid_ff;
   logic [CHAN_W-1:0] s1_max_ff, s1_max_in;
   logic [CHAN_W-1:0] s1_delta_ff, s1_delta_in;
   logic [CHAN_W-1:0] s1_absd_ff, s1_absd_in;
   logic              s1_neg_ff, s1_neg_in;
   sector_type        s1_sector_ff;

   logic              s2_valid_ff;
   div_word_type      s2_num_ff, s2_num_in;
   div_den_type       s2_den_ff, s2_den_in;
   side_type          s2_side_ff, s2_side_in;

   // stage 1: extremes, sector by first channel equal to max, signed difference
   always_comb begin
      mx = (red > green) ? red : green;
      mx = (mx > blue) ? mx : blue;
      mn = (red < green) ? red : green;
      mn = (mn < blue) ? mn : blue;
      if (mx == red) begin
         sector = SECT_RED;
         diff_s = {1'b0, green} - {1'b0, blue};
      end else if (mx == green) begin
         sector = SECT_GREEN;
         diff_s = {1'b0, blue} - {1'b0, red};
      end else begin
         sector = SECT_BLUE;
         diff_s = {1'b0, red} - {1'b0, green};
      end
      s1_max_in   = mx;
      s1_delta_in = mx - mn;
      s1_neg_in   = diff_s[CHAN_W];
      s1_absd_in  = s1_neg_in ? CHAN_W'(-diff_s) : diff_s[CHAN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
      end
      if (en) begin
         s1_max_ff    <= s1_max_in;
         s1_delta_ff  <= s1_delta_in;
         s1_absd_ff   <= s1_absd_in;
         s1_neg_ff    <= s1_neg_in;
         s1_sector_ff <= sector;
      end
   end

   // stage 2: scaled numerators for hue and saturation
   always_comb begin
      s2_num_in[LANE_HUE] = CMP_W'(s1_absd_ff) * CMP_W'(HUE_SPAN);
      s2_num_in[LANE_SAT] = CMP_W'(s1_delta_ff) * CMP_W'(CHAN_MAX);
      s2_den_in[LANE_HUE] = s1_delta_ff;
      s2_den_in[LANE_SAT] = s1_max_ff;
      s2_side_in.value    = s1_max_ff;
      s2_side_in.grey     = (s1_delta_ff == '0);
      s2_side_in.neg      = s1_neg_ff;
      s2_side_in.sector   = s1_sector_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (en) begin
         s2_num_ff  <= s2_num_in;
         s2_den_ff  <= s2_den_in;
         s2_side_ff <= s2_side_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_num   = s2_num_ff;
   assign out_den   = s2_den_ff;
   assign out_side  = s2_side_ff;

endmodule

/* hdl/hsv_div.sv */
// Pipelined restoring divider, one quotient bit per stage, hue and saturation lanes.
`timescale 1ns / 1ps
module hsv_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  hsv_pkg::div_word_type in_num,
   input  hsv_pkg::div_den_type  in_den,
   input  hsv_pkg::side_type     in_side,
   output logic                  out_valid,
   output hsv_pkg::div_quo_type  out_quo,
   output hsv_pkg::side_type     out_side
);
   import hsv_pkg::*;

   logic [DIV_Q_W-1:0] valid_ff;
   div_word_type       rem_ff  [DIV_Q_W];
   div_den_type        den_ff  [DIV_Q_W];
   div_quo_type        quo_ff  [DIV_Q_W];
   side_type           side_ff [DIV_Q_W];

   for (genvar k = 0; k < DIV_Q_W; k++) begin : g_stage
      localparam int Bit = DIV_Q_W - 1 - k;

      logic         src_valid;
      div_word_type src_rem, rem_in;
      div_den_type  src_den;
      div_quo_type  src_quo, quo_in;
      side_type     src_side;

      // stage input: divider operands for the first stage, else the previous stage
      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rem   = in_num;
         assign src_den   = in_den;
         assign src_quo   = '0;
         assign src_side  = in_side;
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_rem   = rem_ff[k-1];
         assign src_den   = den_ff[k-1];
         assign src_quo   = quo_ff[k-1];
         assign src_side  = side_ff[k-1];
      end

      // trial subtract of the shifted divisor in each lane
      always_comb begin
         logic [CMP_W-1:0] trial;
         rem_in = src_rem;
         quo_in = src_quo;
         for (int lane = 0; lane < DIV_LANES; lane++) begin
            trial = CMP_W'(src_den[lane]) << Bit;
            if (src_rem[lane] >= trial) begin
               rem_in[lane]      = src_rem[lane] - trial;
               quo_in[lane][Bit] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= src_valid;
         end
         if (en) begin
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= src_den;
            quo_ff[k]  <= quo_in;
            side_ff[k] <= src_side;
         end
      end
   end

   assign out_valid = valid_ff[DIV_Q_W-1];
   assign out_quo   = quo_ff[DIV_Q_W-1];
   assign out_side  = side_ff[DIV_Q_W-1];

endmodule

/* hdl/hsv_back.sv */
// Final stage: sector offset plus signed quotient, grey and black cases, output register.
`timescale 1ns / 1ps
module hsv_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  hsv_pkg::div_quo_type         in_quo,
   input  hsv_pkg::side_type            in_side,
   output logic                         out_valid,
   output logic [hsv_pkg::HUE_W-1:0]    out_hue,
   output logic [hsv_pkg::CHAN_W-1:0]   out_sat,
   output logic [hsv_pkg::CHAN_W-1:0]   out_value
);
   import hsv_pkg::*;

   logic [HUE_CALC_W-1:0] base, q, hue_calc;
   logic                  valid_ff;
   logic [HUE_W-1:0]      hue_ff, hue_in;
   logic [CHAN_W-1:0]     sat_ff, sat_in;
   logic [CHAN_W-1:0]     value_ff;

   // hue: a negative red-sector result wraps by a full turn
   always_comb begin
      case (in_side.sector)
         SECT_RED:   base = in_side.neg ? HUE_CALC_W'(HUE_FULL) : '0;
         SECT_GREEN: base = HUE_CALC_W'(HUE_GREEN);
         SECT_BLUE:  base = HUE_CALC_W'(HUE_BLUE);
         default:    base = '0;
      endcase
      q        = HUE_CALC_W'(in_quo[LANE_HUE]);
      hue_calc = in_side.neg ? base - q : base + q;
      hue_in   = in_side.grey ? '0 : HUE_W'(hue_calc);
      sat_in   = (in_side.value == '0) ? '0 : CHAN_W'(in_quo[LANE_SAT]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         hue_ff   <= hue_in;
         sat_ff   <= sat_in;
         value_ff <= in_side.value;
      end
   end

   assign out_valid = valid_ff;
   assign out_hue   = hue_ff;
   assign out_sat   = sat_ff;
   assign out_value = value_ff;

endmodule

/* tb/tb_rgb_to_hsv_converter.sv */
// Self-checking testbench for the RGB to HSV converter with random pixel traffic.
`timescale 1ns / 1ps
module tb_rgb_to_hsv_converter;
   import hsv_pkg::*;

   localparam int PIPE_LATENCY = DIV_Q_W + 3;
   localparam int RANDOM_PIXELS = 1650;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD_AT = 300;
   localparam int LONG_HOLD_CYCLES = 400;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [CHAN_W-1:0] sat;
      logic [CHAN_W-1:0] val;
   } hsv_type;

   logic clock;
   logic reset;

   hsv_pixel_if  req_chan ();
   hsv_result_if rsp_chan ();

   rgb_to_hsv_converter uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   pixel_type pixel_queue[$];
   hsv_type   hsv_expected[$];
   int        error_count = 0;
   int        pixels_sent = 0;
   int        results_seen = 0;
   int        cycle_count = 0;
   int        send_gap = 0;
   int        rsp_stall = 0;
   int        long_hold_left = 0;
   bit        long_hold_done = 0;

   // expected HSV of one pixel
   function automatic hsv_type hsv_from_rgb(pixel_type px);
      hsv_type    res;
      int         r, g, b, mx, mn, delta, diff, offset, hue_calc;
      sector_type sector;
      r = int'(px.red);
      g = int'(px.green);
      b = int'(px.blue);
      mx = (r > g) ? r : g;
      mx = (mx > b) ? mx : b;
      mn = (r < g) ? r : g;
      mn = (mn < b) ? mn : b;
      delta = mx - mn;
      hue_calc = 0;
      res.sat = (mx != 0) ? CHAN_W'((delta * CHAN_MAX) / mx) : '0;
      res.val = CHAN_W'(mx);
      if (delta != 0) begin
         // first channel equal to max wins
         if (mx == r) sector = SECT_RED;
         else if (mx == g) sector = SECT_GREEN;
         else sector = SECT_BLUE;
         case (sector)
            SECT_RED: begin
               diff = g - b;
               offset = 0;
            end
            SECT_GREEN: begin
               diff = b - r;
               offset = HUE_GREEN;
            end
            default: begin
               diff = r - g;
               offset = HUE_BLUE;
            end
         endcase
         // int division truncates toward zero
         hue_calc = offset + (HUE_SPAN * diff) / delta;
         if (hue_calc < 0) hue_calc += HUE_FULL;
      end
      res.hue = hue_calc[HUE_W-1:0];
      return res;
   endfunction

   // short gaps mostly, some long ones
   function automatic int draw_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // known values from time zero
   initial begin
      req_chan.valid = 1'b0;
      req_chan.red_in = '0;
      req_chan.green_in = '0;
      req_chan.blue_in = '0;
      rsp_chan.ready = 1'b0;
   end

   // driver: pops pending pixels, logs expected results on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            hsv_expected.push_back(hsv_from_rgb({req_chan.red_in, req_chan.green_in,
                                                 req_chan.blue_in}));
            pixels_sent <= pixels_sent + 1;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               req_chan.valid <= 1'b0;
               send_gap <= send_gap - 1;
            end else if (pixel_queue.size() > 0) begin
               pixel_type px;
               px = pixel_queue.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.red_in <= px.red;
               req_chan.green_in <= px.green;
               req_chan.blue_in <= px.blue;
               // every third stretch of 200 items runs back to back
               send_gap <= ((pixels_sent / 200) % 3 == 1) ? 0 : draw_gap();
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compares each result with the oldest expectation, drives ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_seen <= results_seen + 1;
            if (hsv_expected.size() == 0) begin
               $display("%0t: unexpected result hue %0d sat %0d val %0d", $time,
                        rsp_chan.hue_out, rsp_chan.saturation_out, rsp_chan.value_out);
               error_count <= error_count + 1;
            end else begin
               hsv_type want;
               want = hsv_expected.pop_front();
               if (rsp_chan.hue_out !== want.hue || rsp_chan.saturation_out !== want.sat ||
                   rsp_chan.value_out !== want.val) begin
                  $display({"%0t: mismatch expected hue %0d sat %0d val %0d, ",
                            "got hue %0d sat %0d val %0d"},
                           $time, want.hue, want.sat, want.val, rsp_chan.hue_out,
                           rsp_chan.saturation_out, rsp_chan.value_out);
                  error_count <= error_count + 1;
               end
            end
         end
         if (long_hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
         end else if ((results_seen / 250) % 3 == 2) begin
            rsp_chan.ready <= 1'b1;
         end else if (rsp_stall > 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_stall <= rsp_stall - 1;
         end else if ($urandom_range(0, 99) < 65) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= 1'b0;
            rsp_stall <= draw_gap();
         end
      end
   end

   // one long receiver hold-off so the pipeline fills and input stalls
   always @(posedge clock) begin
      if (reset) begin
         long_hold_left <= 0;
      end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
         long_hold_done <= 1'b1;
         long_hold_left <= LONG_HOLD_CYCLES;
      end else if (long_hold_left > 0) begin
         long_hold_left <= long_hold_left - 1;
      end
   end

   // timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("rgb_to_hsv_converter test failed");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin
      pixel_type px;
      int        kind;
      int        top;
      reset = 1'b1;

      // directed corners
      pixel_queue.push_back({8'd0, 8'd0, 8'd0});        // black
      pixel_queue.push_back({8'd255, 8'd255, 8'd255});  // white
      pixel_queue.push_back({8'd128, 8'd128, 8'd128});  // grey
      pixel_queue.push_back({8'd1, 8'd1, 8'd1});
      pixel_queue.push_back({8'd255, 8'd0, 8'd0});      // pure primaries
      pixel_queue.push_back({8'd0, 8'd255, 8'd0});
      pixel_queue.push_back({8'd0, 8'd0, 8'd255});
      pixel_queue.push_back({8'd255, 8'd255, 8'd0});    // red/green tie
      pixel_queue.push_back({8'd0, 8'd255, 8'd255});    // green/blue tie
      pixel_queue.push_back({8'd255, 8'd0, 8'd255});    // red/blue tie
      pixel_queue.push_back({8'd200, 8'd200, 8'd17});
      pixel_queue.push_back({8'd255, 8'd0, 8'd1});      // red sector, negative hue wraps
      pixel_queue.push_back({8'd255, 8'd1, 8'd0});
      pixel_queue.push_back({8'd1, 8'd0, 8'd0});        // smallest nonzero max
      pixel_queue.push_back({8'd0, 8'd1, 8'd0});
      pixel_queue.push_back({8'd0, 8'd0, 8'd1});
      pixel_queue.push_back({8'd255, 8'd254, 8'd254});  // delta of one at top
      pixel_queue.push_back({8'd0, 8'd255, 8'd254});
      pixel_queue.push_back({8'd254, 8'd0, 8'd255});
      pixel_queue.push_back({8'd170, 8'd85, 8'd0});
      pixel_queue.push_back({8'd3, 8'd2, 8'd1});
      pixel_queue.push_back({8'd85, 8'd170, 8'd255});

      // random pixels with a bias toward ties, greys and small deltas
      repeat (RANDOM_PIXELS) begin
         kind = $urandom_range(0, 99);
         px.red = CHAN_W'($urandom_range(0, 255));
         px.green = CHAN_W'($urandom_range(0, 255));
         px.blue = CHAN_W'($urandom_range(0, 255));
         if (kind < 50) begin
            // uniform
         end else if (kind < 65) begin
            top = $urandom_range(0, 255);
            case ($urandom_range(0, 2))
               0: begin
                  px.red = CHAN_W'(top);
                  px.green = CHAN_W'(top);
                  px.blue = CHAN_W'($urandom_range(0, top));
               end
               1: begin
                  px.green = CHAN_W'(top);
                  px.blue = CHAN_W'(top);
                  px.red = CHAN_W'($urandom_range(0, top));
               end
               default: begin
                  px.red = CHAN_W'(top);
                  px.blue = CHAN_W'(top);
                  px.green = CHAN_W'($urandom_range(0, top));
               end
            endcase
         end else if (kind < 75) begin
            px.green = px.red;
            px.blue = px.red;
         end else if (kind < 90) begin
            top = $urandom_range(3, 255);
            px.red = CHAN_W'(top - int'($urandom_range(0, 3)));
            px.green = CHAN_W'(top - int'($urandom_range(0, 3)));
            px.blue = CHAN_W'(top - int'($urandom_range(0, 3)));
         end else begin
            px.red = ($urandom_range(0, 1) != 0) ? 8'd255 : px.red;
            px.green = ($urandom_range(0, 2) == 0) ? 8'd0 : px.green;
            px.blue = ($urandom_range(0, 2) == 0) ? 8'd255 : 8'd0;
         end
         pixel_queue.push_back(px);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // all pixels accepted, then drain
      while (pixel_queue.size() > 0 || req_chan.valid) @(posedge clock);
      while (hsv_expected.size() > 0) @(posedge clock);
      repeat (2 * PIPE_LATENCY) @(posedge clock);

      if (error_count == 0) begin
         $display("rgb_to_hsv_converter test passed");
      end else begin
         $display("rgb_to_hsv_converter test failed");
      end
      $finish;
   end

endmodule
